// ===== design/serial_frame_builder_sum_checksum_unit_defines.svh =====
`ifndef SERIAL_FRAME_BUILDER_SUM_CHECKSUM_UNIT_DEFINES_SVH
`define SERIAL_FRAME_BUILDER_SUM_CHECKSUM_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SFBSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SFBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== design/sfbsc_pkg.sv =====
`timescale 1ns / 1ps
package sfbsc_pkg;

	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h55;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] IDX_HDR_A = 4'd0;
	localparam logic [3:0] IDX_HDR_B = 4'd1;
	localparam logic [3:0] IDX_CODE = 4'd2;
	localparam logic [3:0] IDX_LEN_HI = 4'd3;
	localparam logic [3:0] IDX_LEN_LO = 4'd4;
	localparam logic [3:0] IDX_PAY0 = 4'd5;
	localparam logic [3:0] IDX_PAY1 = 4'd6;
	localparam logic [3:0] IDX_PAY2 = 4'd7;
	localparam logic [3:0] IDX_PAY3 = 4'd8;
	localparam logic [3:0] IDX_SUM = 4'd9;
	localparam logic [3:0] IDX_TRL_B = 4'd10;
	localparam logic [3:0] IDX_TRL_A = 4'd11;

	typedef struct packed {
		logic [31:0] word;
		logic [7:0]  code;
		logic [6:0]  count;
		logic        port;
		logic        header;
		logic        trailer;
	} cmd_t;

endpackage

// ===== design/serial_frame_builder_sum_checksum_unit.sv =====
`timescale 1ns / 1ps
`include "serial_frame_builder_sum_checksum_unit_defines.svh"
// Turns 32-bit payload words into serial link frames with an additive checksum.
// The slave side takes one request per word; start_frame opens a frame with the
// header AA 55, frame code and 16-bit big-endian byte length. Each word then
// yields its four bytes, low byte first, and the last word of a frame adds the
// 8-bit sum of the frame bytes followed by 55 AA. A word without start while no
// frame is open is dropped, and a start mid-frame abandons the open frame.
// The master side carries one byte per request, with the port and an end-of-item
// flag in tuser and the closing AA of a frame marked by tlast.
// An accepted word is written into the queue, and its first byte then goes from
// the queue head into the single output byte register. That register sends one
// byte per cycle while a word waits and the receiver is ready; a middle word
// gives 4 bytes, an opening word 9, a closing word 7, a one-word frame 12 and a
// dropped word none. A two-entry queue lets the input side take the next word while
// bytes of earlier ones still wait on the output.
// Reset clears the frame state, the queue and the output valid flag.
// When the receiver stalls, the output byte holds and the queue fills, after
// which s_tready falls until bytes drain.
module serial_frame_builder_sum_checksum_unit #(
	parameter int unsigned MAX_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // payload_word[31:0], frame_code[39:32], word_count[46:40]
	input  logic [1:0]  s_tuser,  // start_frame[0], port_select[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_byte[7:0]
	output logic [1:0]  m_tuser,  // out_port[0], item_last[1]
	output logic        m_tlast
);
	import sfbsc_pkg::*;

	logic              q_push;
	cmd_t              q_cmd;
	logic              q_full;
	logic              q_pop;
	logic              head_valid;
	cmd_t              head_cmd;
	logic [QCNT_W-1:0] q_count;

	sfbsc_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(q_cmd)
	);

	sfbsc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(q_cmd),
		.full(q_full),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.count(q_count)
	);

	sfbsc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	`SFBSC_ASSERT_SAME(a_frame_end_is_sync, clk, arst_n, m_tvalid && m_tlast, m_tuser[1] && (m_tdata == SYNC_A))
	`SFBSC_ASSERT_NEXT(a_pop_marks_item_last, clk, arst_n, q_pop, m_tvalid && m_tuser[1])
	`SFBSC_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, q_push, q_count != '0)

endmodule

// ===== design/sfbsc_front.sv =====
`timescale 1ns / 1ps
module sfbsc_front #(
	parameter int unsigned MAX_WORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,
	input  logic [1:0]         s_tuser,
	input  logic               q_full,
	output logic               q_push,
	output sfbsc_pkg::cmd_t    q_cmd
);
	import sfbsc_pkg::*;

	logic       frame_open_q;
	logic [6:0] words_left_q;
	logic       frame_port_q;

	logic       accept;
	logic       start;
	logic [6:0] count_raw;
	logic [6:0] count_min;
	logic [6:0] count_sat;
	logic [6:0] left_next;

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign start = s_tuser[0];
	assign count_raw = s_tdata[46:40];
	assign count_min = (count_raw == 7'd0) ? 7'd1 : count_raw;
	assign count_sat = (32'(count_min) > 32'(MAX_WORDS)) ? 7'(MAX_WORDS) : count_min;
	assign left_next = start ? (count_sat - 7'd1) : (words_left_q - 7'd1);

	assign q_push = accept && (start || frame_open_q);

	always_comb begin
		q_cmd.word = s_tdata[31:0];
		q_cmd.code = s_tdata[39:32];
		q_cmd.count = count_sat;
		q_cmd.port = start ? s_tuser[1] : frame_port_q;
		q_cmd.header = start;
		q_cmd.trailer = (left_next == 7'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			words_left_q <= 7'd0;
			frame_port_q <= 1'b0;
		end else if (q_push) begin
			frame_open_q <= (left_next != 7'd0);
			words_left_q <= left_next;
			if (start) begin
				frame_port_q <= s_tuser[1];
			end
		end
	end

endmodule

// ===== design/sfbsc_queue.sv =====
`timescale 1ns / 1ps
module sfbsc_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  sfbsc_pkg::cmd_t            push_cmd,
	output logic                       full,
	input  logic                       pop,
	output logic                       head_valid,
	output sfbsc_pkg::cmd_t            head_cmd,
	output logic [sfbsc_pkg::QCNT_W-1:0] count
);
	import sfbsc_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/sfbsc_back.sv =====
`timescale 1ns / 1ps
module sfbsc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  sfbsc_pkg::cmd_t head_cmd,
	output logic            pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic [1:0]      m_tuser,
	output logic            m_tlast
);
	import sfbsc_pkg::*;

	logic       started_q;
	logic [3:0] idx_q;
	logic [7:0] sum_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       port_q;
	logic       end_q;
	logic       last_q;

	logic       advance;
	logic [3:0] cur_idx;
	logic [3:0] end_idx;
	logic [7:0] byte_val;
	logic [8:0] len;

	assign advance = head_valid && (!valid_q || m_tready);
	assign cur_idx = started_q ? idx_q : (head_cmd.header ? IDX_HDR_A : IDX_PAY0);
	assign end_idx = head_cmd.trailer ? IDX_TRL_A : IDX_PAY3;
	assign pop = advance && (cur_idx == end_idx);
	assign len = {head_cmd.count, 2'b00};

	always_comb begin
		unique case (cur_idx)
			IDX_HDR_A: byte_val = SYNC_A;
			IDX_HDR_B: byte_val = SYNC_B;
			IDX_CODE: byte_val = head_cmd.code;
			IDX_LEN_HI: byte_val = {7'd0, len[8]};
			IDX_LEN_LO: byte_val = len[7:0];
			IDX_PAY0: byte_val = head_cmd.word[7:0];
			IDX_PAY1: byte_val = head_cmd.word[15:8];
			IDX_PAY2: byte_val = head_cmd.word[23:16];
			IDX_PAY3: byte_val = head_cmd.word[31:24];
			IDX_SUM: byte_val = sum_q;
			IDX_TRL_B: byte_val = SYNC_B;
			IDX_TRL_A: byte_val = SYNC_A;
			default: byte_val = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			idx_q <= IDX_HDR_A;
			sum_q <= 8'd0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				sum_q <= (cur_idx == IDX_HDR_A) ? byte_val : sum_q + byte_val;
				if (cur_idx == end_idx) begin
					started_q <= 1'b0;
				end else begin
					started_q <= 1'b1;
					idx_q <= cur_idx + 4'd1;
				end
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= byte_val;
			port_q <= head_cmd.port;
			end_q <= (cur_idx == IDX_TRL_A);
			last_q <= (cur_idx == end_idx);
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = data_q;
	assign m_tuser = {last_q, port_q};
	assign m_tlast = end_q;

endmodule
